/* rtl/core/sortpq_pkg.sv */
// sortpq_pkg: shared types and codes for the sorted priority queue.
// Used by sortpq_ctrl, sortpq_dpath and sorted_priority_queue; no dependencies.
package sortpq_pkg;

   // request function codes
   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   // result status codes
   localparam logic [1:0] STAT_ENQUEUED = 2'd0;
   localparam logic [1:0] STAT_DEQUEUED = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;
   localparam logic [1:0] STAT_EMPTY    = 2'd3;

   localparam int          CSR_WIDTH = 5;
   localparam logic [4:0]  CAP_RESET = 5'd16;
   localparam int          RSP_WIDTH = 32;

   // datapath operation codes
   typedef logic [3:0] op_type;
   localparam op_type OP_NONE         = 4'd0;
   localparam op_type OP_ENQ_START    = 4'd1;
   localparam op_type OP_DEQ_START    = 4'd2;
   localparam op_type OP_REJECT_FULL  = 4'd3;
   localparam op_type OP_REJECT_EMPTY = 4'd4;
   localparam op_type OP_SHIFT        = 4'd5;
   localparam op_type OP_INSERT       = 4'd6;
   localparam op_type OP_POP          = 4'd7;
   localparam op_type OP_PUSH_RSP     = 4'd8;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic full;
      logic shift_more;   // entry under scan is >= new value, move it up
      logic idx_is_one;
      logic rsp_free;
   } stat_type;

endpackage

/* rtl/core/sortpq_ctrl.sv */
// sortpq_ctrl: sequencer for enqueue scan, dequeue and result hand-off.
// Depends on sortpq_pkg; drives commands into sortpq_dpath.
module sortpq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_func,
   output logic                 req_stall,
   input  sortpq_pkg::stat_type stat,
   output sortpq_pkg::cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_PLACE = 3'd2;
   localparam logic [2:0] ST_DEQ   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = sortpq_pkg::OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == sortpq_pkg::FUNC_ENQ) begin
                  if (stat.full) begin
                     cmd.op   = sortpq_pkg::OP_REJECT_FULL;
                     state_in = ST_DONE;
                  end else begin
                     cmd.op   = sortpq_pkg::OP_ENQ_START;
                     state_in = stat.count_zero ? ST_PLACE : ST_SCAN;
                  end
               end else begin
                  if (stat.count_zero) begin
                     cmd.op   = sortpq_pkg::OP_REJECT_EMPTY;
                     state_in = ST_DONE;
                  end else begin
                     cmd.op   = sortpq_pkg::OP_DEQ_START;
                     state_in = ST_DEQ;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (stat.shift_more) begin
               cmd.op   = sortpq_pkg::OP_SHIFT;
               state_in = stat.idx_is_one ? ST_PLACE : ST_SCAN;
            end else begin
               cmd.op   = sortpq_pkg::OP_INSERT;
               state_in = ST_DONE;
            end
         end
         ST_PLACE: begin
            cmd.op   = sortpq_pkg::OP_INSERT;
            state_in = ST_DONE;
         end
         ST_DEQ: begin
            cmd.op   = sortpq_pkg::OP_POP;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.op   = sortpq_pkg::OP_PUSH_RSP;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a request is only taken in idle
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (state_ff == ST_IDLE))
      else $error("request accepted outside idle");

   // scan only starts on a queue that holds entries
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !stat.count_zero)
      else $error("scan with empty queue");

   // every accepted request ends in a result push before the next accept
   a_done_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && stat.rsp_free) |=> (state_ff == ST_IDLE))
      else $error("result not handed off");

endmodule

/* rtl/core/sortpq_dpath.sv */
// sortpq_dpath: entry memory (circular, sorted from head), count, scan index,
// capacity register and result registers. Depends on sortpq_pkg.
module sortpq_dpath #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sortpq_pkg::cmd_type                  cmd,
   output sortpq_pkg::stat_type                 stat,
   input  logic [31:0]                          req_value_in,
   input  logic                                 csr_write,
   input  logic [sortpq_pkg::CSR_WIDTH-1:0]     csr_capacity_in_use,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sortpq_pkg::RSP_WIDTH-1:0]     rsp_value_out,
   output logic [1:0]                           rsp_status,
   output logic [4:0]                           rsp_count_out
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int DW = DATA_WIDTH;
   localparam int SW = sortpq_pkg::CSR_WIDTH;
   localparam logic [AW:0]   CAP_SUM   = (AW + 1)'(CAPACITY);
   localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
   localparam logic [AW-1:0] HEAD_LAST = AW'(CAPACITY - 1);

   // entry memory
   logic [DW-1:0] entry_mem [CAPACITY];
   logic [DW-1:0] rd_data_ff;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [DW-1:0] val_ff, val_in;
   logic [SW-1:0] cap_ff;
   logic [1:0]    res_status_ff, res_status_in;
   logic [31:0]   res_value_ff, res_value_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [4:0]    rsp_count_ff, rsp_count_in;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_log, wr_log;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [DW-1:0] wr_data;
   logic [DW+31:0] value_ext;
   logic [DW+31:0] rd_sext;
   logic [CW+4:0]  count_ext;
   logic [CW+SW-1:0] count_cmp, cap_cmp;

   // logical slot (offset from head) to memory row
   function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] l,
                                              input logic [AW-1:0] h);
      logic [AW:0] s;
      s = {1'b0, h} + {1'b0, l};
      if (s >= CAP_SUM) begin
         s = s - CAP_SUM;
      end
      return s[AW-1:0];
   endfunction

   assign value_ext = {{DW{1'b0}}, req_value_in};
   assign rd_sext   = {{32{rd_data_ff[DW-1]}}, rd_data_ff};
   assign count_ext = {5'd0, count_ff};
   assign count_cmp = {{SW{1'b0}}, count_ff};
   assign cap_cmp   = {{CW{1'b0}}, cap_ff};

   assign rd_addr = to_phys(rd_log, head_ff);
   assign wr_addr = to_phys(wr_log, head_ff);

   assign stat.count_zero = (count_ff == '0);
   assign stat.full       = (count_ff == CAP_CNT) || (count_cmp >= cap_cmp);
   assign stat.shift_more = ($signed(rd_data_ff) >= $signed(val_ff));
   assign stat.idx_is_one = (idx_ff == AW'(1));
   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      rd_log        = '0;
      wr_log        = '0;
      wr_data       = val_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      case (cmd.op)
         sortpq_pkg::OP_ENQ_START: begin
            val_in = value_ext[DW-1:0];
            idx_in = count_ff[AW-1:0];
            rd_en  = 1'b1;
            rd_log = count_ff[AW-1:0] - AW'(1);
         end
         sortpq_pkg::OP_DEQ_START: begin
            rd_en  = 1'b1;
            rd_log = '0;
         end
         sortpq_pkg::OP_REJECT_FULL: begin
            res_status_in = sortpq_pkg::STAT_FULL;
            res_value_in  = '0;
         end
         sortpq_pkg::OP_REJECT_EMPTY: begin
            res_status_in = sortpq_pkg::STAT_EMPTY;
            res_value_in  = '0;
         end
         sortpq_pkg::OP_SHIFT: begin
            // move the entry up one slot and fetch the one below it
            wr_en   = 1'b1;
            wr_log  = idx_ff;
            wr_data = rd_data_ff;
            idx_in  = idx_ff - AW'(1);
            rd_en   = 1'b1;
            rd_log  = idx_ff - AW'(2);
         end
         sortpq_pkg::OP_INSERT: begin
            wr_en         = 1'b1;
            wr_log        = idx_ff;
            wr_data       = val_ff;
            count_in      = count_ff + CW'(1);
            res_status_in = sortpq_pkg::STAT_ENQUEUED;
            res_value_in  = '0;
         end
         sortpq_pkg::OP_POP: begin
            res_value_in  = rd_sext[31:0];
            res_status_in = sortpq_pkg::STAT_DEQUEUED;
            count_in      = count_ff - CW'(1);
            head_in       = (head_ff == HEAD_LAST) ? '0 : head_ff + AW'(1);
         end
         sortpq_pkg::OP_PUSH_RSP: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = res_value_ff;
            rsp_status_in = res_status_ff;
            rsp_count_in  = count_ext[4:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= sortpq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            cap_ff <= csr_capacity_in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count_out = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("count above capacity");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, head_ff} < CAP_SUM)
      else $error("head out of range");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == sortpq_pkg::OP_INSERT) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not grow count");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == sortpq_pkg::OP_POP) |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("pop did not shrink count");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == sortpq_pkg::OP_PUSH_RSP) |-> stat.rsp_free)
      else $error("result overwritten while waiting");

endmodule

/* rtl/core/sorted_priority_queue.sv */
// Sorted priority queue, smallest value first. A full or empty rejection goes
// straight to the result hand-off, a dequeue pops the head first, and an enqueue
// first moves any held entries >= the new value up (one entry per cycle, one memory port).
// A new request is taken once the previous transaction's result is registered.
// Reset (synchronous): count and head to zero, capacity_in_use to 16; the entry
// memory is not cleared, slots beyond the count are never read.
module sorted_priority_queue #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_value_in,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value_out,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_count_out,
   // capacity register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_capacity_in_use
);

   // Entries live in a circular memory, sorted ascending from the head slot.
   // Dequeue reads the head and advances it. Enqueue walks down from the tail,
   // moving each entry >= the new value up one slot, then writes the new value
   // into the gap.
   sortpq_pkg::cmd_type  cmd;
   sortpq_pkg::stat_type stat;

   // register writes must arrive only while the queue is idle (the block does not enforce it); always taken
   assign csr_ready = 1'b1;

   sortpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sortpq_dpath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_value_in        (req_value_in),
      .csr_write           (csr_valid && csr_ready),
      .csr_capacity_in_use (csr_capacity_in_use),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_value_out       (rsp_value_out),
      .rsp_status          (rsp_status),
      .rsp_count_out       (rsp_count_out)
   );

endmodule
